// ===== src/sphf_pkg.sv =====
// Shared types, constants and register codes of the spectrum peak-hold meter.
// Used by every module of the block but sphf_ram; depends on nothing.
package sphf_pkg;

  localparam int LEVEL_W  = 16;
  localparam int BIN_W    = 9;
  localparam int TIME_W   = 16;
  localparam int BINS_DEF = 512;
  localparam int PADDR_W  = 4;
  localparam int PDATA_W  = 32;

  localparam logic signed [LEVEL_W-1:0] FLOOR_RST = 16'shA000;
  localparam logic [TIME_W-1:0]         HOLD_RST  = 16'd500;
  localparam logic [TIME_W-1:0]         FALL_RST  = 16'd5;

  localparam logic [1:0] REG_FLOOR = 2'd0;
  localparam logic [1:0] REG_HOLD  = 2'd1;
  localparam logic [1:0] REG_FALL  = 2'd2;

  localparam logic FUNC_UPDATE = 1'b0;
  localparam logic FUNC_CLEAR  = 1'b1;

  typedef struct packed {
    logic                      func;
    logic [BIN_W-1:0]          bin;
    logic signed [LEVEL_W-1:0] in_level;
    logic                      in_valid;
    logic signed [LEVEL_W-1:0] out_level;
    logic                      out_valid;
    logic [TIME_W-1:0]         elapsed_ms;
  } in_item_t;

  typedef struct packed {
    logic [BIN_W-1:0]          bin_out;
    logic signed [LEVEL_W-1:0] in_curve;
    logic signed [LEVEL_W-1:0] out_curve;
    logic signed [LEVEL_W-1:0] peak_max;
  } out_item_t;

  typedef struct packed {
    logic signed [LEVEL_W-1:0] floor_level;
    logic [TIME_W-1:0]         hold_time_ms;
    logic [TIME_W-1:0]         fall_rate;
  } sphf_cfg_t;

  typedef struct packed {
    logic re;
    logic upd;
    logic clr;
  } sphf_lane_ctl_t;

endpackage

// ===== src/spectrum_peak_hold_fall_unit.sv =====
// Top level of the two-channel spectrum peak-hold meter with linear fall.
// Depends on sphf_pkg, sphf_cfg, sphf_lane and sphf_ram.

// The block takes one bin transaction per clock cycle while the output does
// not stall and no clearing pass runs. A read stage reads the bin's stores;
// an update stage then runs both channel lanes side by side, updates the
// max-hold store from the out level, writes the stores back and loads the
// output register. A write-forwarding register in each store lets the same
// bin arrive in consecutive cycles. After reset a clearing pass walks every
// store address and loads each entry with its reset value; in_ready stays
// low during that pass while configuration writes are taken as usual. Bins
// at or beyond BINS change no state and report the floor level.
module spectrum_peak_hold_fall_unit #(
  parameter int BINS = sphf_pkg::BINS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  sphf_pkg::in_item_t           in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output sphf_pkg::out_item_t          out_data,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [sphf_pkg::PADDR_W-1:0] paddr,
  input  logic [sphf_pkg::PDATA_W-1:0] pwdata,
  output logic [sphf_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);
  import sphf_pkg::*;

  localparam int AW = $clog2(BINS);

  sphf_cfg_t                 cfg;
  logic                      accept;
  logic                      s1_adv;
  logic [AW-1:0]             raddr;

  logic                      clearing_r;
  logic [AW-1:0]             clr_addr_r;

  logic                      s1_valid_r;
  logic                      s1_func_r;
  logic                      s1_hit_r;
  logic [BIN_W-1:0]          s1_bin_r;
  logic [AW-1:0]             s1_addr_r;
  logic signed [LEVEL_W-1:0] s1_lin_r;
  logic signed [LEVEL_W-1:0] s1_lout_r;
  logic [TIME_W-1:0]         s1_dt_r;

  logic                      out_valid_r;
  out_item_t                 out_data_r;
  out_item_t                 out_data_nxt;

  sphf_lane_ctl_t            lane_ctl;
  logic signed [LEVEL_W-1:0] in_old;
  logic signed [LEVEL_W-1:0] in_new;
  logic signed [LEVEL_W-1:0] out_old;
  logic signed [LEVEL_W-1:0] out_new;

  logic [LEVEL_W-1:0]        pk_rdata;
  logic                      pk_we;
  logic [AW-1:0]             pk_waddr;
  logic [LEVEL_W-1:0]        pk_wdata;
  logic                      pk_byp_v_r;
  logic [AW-1:0]             pk_byp_addr_r;
  logic [LEVEL_W-1:0]        pk_byp_data_r;
  logic signed [LEVEL_W-1:0] pk_old;
  logic signed [LEVEL_W-1:0] pk_new;

  sphf_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !clearing_r && (!s1_valid_r || s1_adv);
  assign accept   = in_valid && in_ready;
  assign raddr    = AW'(in_data.bin);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clearing_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == AW'(BINS - 1)) begin
        clearing_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_func_r <= in_data.func;
      s1_hit_r  <= 32'(in_data.bin) < BINS;
      s1_bin_r  <= in_data.bin;
      s1_addr_r <= raddr;
      s1_lin_r  <= in_data.in_valid ? in_data.in_level : cfg.floor_level;
      s1_lout_r <= in_data.out_valid ? in_data.out_level : cfg.floor_level;
      s1_dt_r   <= in_data.elapsed_ms;
    end
  end

  assign lane_ctl = '{re:  accept,
                      upd: s1_adv && s1_hit_r && (s1_func_r == FUNC_UPDATE),
                      clr: clearing_r};

  sphf_lane #(.BINS(BINS)) u_lane_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (lane_ctl),
    .raddr     (raddr),
    .s1_addr   (s1_addr_r),
    .clr_addr  (clr_addr_r),
    .cfg       (cfg),
    .level     (s1_lin_r),
    .dt        (s1_dt_r),
    .curve_old (in_old),
    .curve_new (in_new)
  );

  sphf_lane #(.BINS(BINS)) u_lane_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (lane_ctl),
    .raddr     (raddr),
    .s1_addr   (s1_addr_r),
    .clr_addr  (clr_addr_r),
    .cfg       (cfg),
    .level     (s1_lout_r),
    .dt        (s1_dt_r),
    .curve_old (out_old),
    .curve_new (out_new)
  );

  sphf_ram #(.WIDTH(LEVEL_W), .DEPTH(BINS)) u_peak_ram (
    .clk   (clk),
    .re    (accept),
    .raddr (raddr),
    .rdata (pk_rdata),
    .we    (pk_we),
    .waddr (pk_waddr),
    .wdata (pk_wdata)
  );

  assign pk_old = (pk_byp_v_r && pk_byp_addr_r == s1_addr_r) ? pk_byp_data_r : pk_rdata;

  always_comb begin
    if (s1_func_r == FUNC_CLEAR) begin
      pk_new = cfg.floor_level;
    end else if (s1_lout_r > pk_old) begin
      pk_new = s1_lout_r;
    end else begin
      pk_new = pk_old;
    end
  end

  assign pk_we    = clearing_r || (s1_adv && s1_hit_r);
  assign pk_waddr = clearing_r ? clr_addr_r : s1_addr_r;
  assign pk_wdata = clearing_r ? FLOOR_RST : pk_new;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pk_byp_v_r <= 1'b0;
    end else if (pk_we) begin
      pk_byp_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pk_we) begin
      pk_byp_addr_r <= pk_waddr;
      pk_byp_data_r <= pk_wdata;
    end
  end

  always_comb begin
    out_data_nxt.bin_out = s1_bin_r;
    if (!s1_hit_r) begin
      out_data_nxt.in_curve  = cfg.floor_level;
      out_data_nxt.out_curve = cfg.floor_level;
      out_data_nxt.peak_max  = cfg.floor_level;
    end else if (s1_func_r == FUNC_CLEAR) begin
      out_data_nxt.in_curve  = in_old;
      out_data_nxt.out_curve = out_old;
      out_data_nxt.peak_max  = pk_new;
    end else begin
      out_data_nxt.in_curve  = in_new;
      out_data_nxt.out_curve = out_new;
      out_data_nxt.peak_max  = pk_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== src/sphf_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; instantiated for every per-bin store.
module sphf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/sphf_cfg.sv =====
// APB-style configuration registers: floor level, hold time and fall rate.
// Depends on sphf_pkg.
module sphf_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sphf_pkg::PADDR_W-1:0] paddr,
  input  logic [sphf_pkg::PDATA_W-1:0] pwdata,
  output logic [sphf_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  output sphf_pkg::sphf_cfg_t         cfg
);
  import sphf_pkg::*;

  sphf_cfg_t  cfg_r;
  sphf_cfg_t  cfg_nxt;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[3:2];

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        REG_FLOOR: cfg_nxt.floor_level  = pwdata[LEVEL_W-1:0];
        REG_HOLD:  cfg_nxt.hold_time_ms = pwdata[TIME_W-1:0];
        REG_FALL:  cfg_nxt.fall_rate    = pwdata[TIME_W-1:0];
        default:   cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.floor_level  <= FLOOR_RST;
      cfg_r.hold_time_ms <= HOLD_RST;
      cfg_r.fall_rate    <= FALL_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    case (reg_idx)
      REG_FLOOR: prdata = {16'h0000, cfg_r.floor_level};
      REG_HOLD:  prdata = {16'h0000, cfg_r.hold_time_ms};
      REG_FALL:  prdata = {16'h0000, cfg_r.fall_rate};
      default:   prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

// ===== src/sphf_lane.sv =====
// One channel lane: curve and hold-timer store with write forwarding and the
// hold-then-linear-fall ballistics. Depends on sphf_pkg and sphf_ram.
module sphf_lane #(
  parameter int BINS = sphf_pkg::BINS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  sphf_pkg::sphf_lane_ctl_t         ctl,
  input  logic [$clog2(BINS)-1:0]          raddr,
  input  logic [$clog2(BINS)-1:0]          s1_addr,
  input  logic [$clog2(BINS)-1:0]          clr_addr,
  input  sphf_pkg::sphf_cfg_t              cfg,
  input  logic signed [sphf_pkg::LEVEL_W-1:0] level,
  input  logic [sphf_pkg::TIME_W-1:0]      dt,
  output logic signed [sphf_pkg::LEVEL_W-1:0] curve_old,
  output logic signed [sphf_pkg::LEVEL_W-1:0] curve_new
);
  import sphf_pkg::*;

  localparam int AW = $clog2(BINS);
  localparam int DW = LEVEL_W + TIME_W;

  logic [DW-1:0]             rdata;
  logic                      we;
  logic [AW-1:0]             waddr;
  logic [DW-1:0]             wdata;
  logic                      byp_v_r;
  logic [AW-1:0]             byp_addr_r;
  logic [DW-1:0]             byp_data_r;
  logic [DW-1:0]             cur;
  logic signed [LEVEL_W-1:0] curve;
  logic [TIME_W-1:0]         hold;
  logic [TIME_W-1:0]         fall_dt;
  logic [TIME_W-1:0]         hold_new;
  logic [2*TIME_W-1:0]       drop;
  logic signed [LEVEL_W:0]   gap;
  logic signed [LEVEL_W-1:0] fallen;

  sphf_ram #(.WIDTH(DW), .DEPTH(BINS)) u_ram (
    .clk   (clk),
    .re    (ctl.re),
    .raddr (raddr),
    .rdata (rdata),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata)
  );

  assign cur   = (byp_v_r && byp_addr_r == s1_addr) ? byp_data_r : rdata;
  assign curve = cur[DW-1:TIME_W];
  assign hold  = cur[TIME_W-1:0];

  assign fall_dt  = (dt > hold) ? dt - hold : '0;
  assign hold_new = (hold > dt) ? hold - dt : '0;
  assign drop     = cfg.fall_rate * fall_dt;
  assign gap      = {curve[LEVEL_W-1], curve} - {level[LEVEL_W-1], level};
  assign fallen   = curve - LEVEL_W'(drop[LEVEL_W-1:0]);

  logic signed [LEVEL_W-1:0] curve_nx;
  logic [TIME_W-1:0]         hold_nx;

  always_comb begin
    if (level >= curve) begin
      curve_nx = level;
      hold_nx  = cfg.hold_time_ms;
    end else begin
      hold_nx  = hold_new;
      curve_nx = (drop >= (2*TIME_W)'(unsigned'(gap))) ? level : fallen;
    end
  end

  assign we    = ctl.upd || ctl.clr;
  assign waddr = ctl.clr ? clr_addr : s1_addr;
  assign wdata = ctl.clr ? {FLOOR_RST, {TIME_W{1'b0}}} : {curve_nx, hold_nx};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_v_r <= 1'b0;
    end else if (we) begin
      byp_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      byp_addr_r <= waddr;
      byp_data_r <= wdata;
    end
  end

  assign curve_old = curve;
  assign curve_new = curve_nx;

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for spectrum_peak_hold_fall_unit: directed and random bin traffic,
// APB register phases, random stalls on both streams, a scoreboard fed by a behavioral meter.
// Depends on sphf_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module tb;
  import sphf_pkg::*;

  localparam logic [1:0] REG_SPARE = 2'd3;
  localparam int N_PHASES = 6;
  localparam int PHASE_ITEMS = 155;

  typedef struct packed {
    logic signed [LEVEL_W-1:0] curve;
    logic [TIME_W-1:0]         hold;
  } lane_t;

  typedef struct packed {
    in_item_t  item;
    logic      typed;
    out_item_t want;
  } step_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  in_item_t in_data;
  out_item_t out_data;
  logic psel, penable, pwrite, pready;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata, prdata;

  logic signed [LEVEL_W-1:0] floor_q;
  logic [TIME_W-1:0] hold_q, fall_q;
  logic signed [LEVEL_W-1:0] in_curve_mem [BINS_DEF];
  logic signed [LEVEL_W-1:0] out_curve_mem [BINS_DEF];
  logic signed [LEVEL_W-1:0] peak_mem [BINS_DEF];
  logic [TIME_W-1:0] in_hold_mem [BINS_DEF];
  logic [TIME_W-1:0] out_hold_mem [BINS_DEF];

  out_item_t pending_results[$];
  step_t steps[$];
  int fault_count = 0;
  bit sink_calm = 1'b0;

  spectrum_peak_hold_fall_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic flag(string what);
    fault_count++;
    if (fault_count <= 100) $display("%0t tb mismatch: %s", $realtime, what);
  endtask

  function automatic lane_t lane_step(logic signed [LEVEL_W-1:0] level, lane_t cur,
                                      logic [TIME_W-1:0] dt);
    lane_t nxt;
    logic [TIME_W-1:0] fall_dt;
    longint drop_to;
    nxt = cur;
    fall_dt = dt;
    if (level >= cur.curve) begin
      nxt.curve = level;
      nxt.hold = hold_q;
    end else begin
      if (cur.hold != '0) begin
        fall_dt = (dt > cur.hold) ? dt - cur.hold : '0;
        nxt.hold = (cur.hold > dt) ? cur.hold - dt : '0;
      end
      drop_to = longint'(cur.curve) - longint'(fall_q) * longint'(fall_dt);
      if (drop_to < longint'(level)) drop_to = longint'(level);
      nxt.curve = drop_to[LEVEL_W-1:0];
    end
    return nxt;
  endfunction

  function automatic out_item_t meter_update(in_item_t it);
    logic signed [LEVEL_W-1:0] lin, lout;
    lane_t a, b;
    out_item_t r;
    lin = it.in_valid ? it.in_level : floor_q;
    lout = it.out_valid ? it.out_level : floor_q;
    if (it.func == FUNC_CLEAR) begin
      peak_mem[it.bin] = floor_q;
    end else begin
      if (lout > peak_mem[it.bin]) peak_mem[it.bin] = lout;
      a.curve = in_curve_mem[it.bin];
      a.hold = in_hold_mem[it.bin];
      b.curve = out_curve_mem[it.bin];
      b.hold = out_hold_mem[it.bin];
      a = lane_step(lin, a, it.elapsed_ms);
      b = lane_step(lout, b, it.elapsed_ms);
      in_curve_mem[it.bin] = a.curve;
      in_hold_mem[it.bin] = a.hold;
      out_curve_mem[it.bin] = b.curve;
      out_hold_mem[it.bin] = b.hold;
    end
    r.bin_out = it.bin;
    r.in_curve = in_curve_mem[it.bin];
    r.out_curve = out_curve_mem[it.bin];
    r.peak_max = peak_mem[it.bin];
    return r;
  endfunction

  function automatic in_item_t mk(logic f, int b, int il, logic iv, int ol, logic ov, int dt);
    in_item_t it;
    it.func = f;
    it.bin = BIN_W'(b);
    it.in_level = LEVEL_W'(il);
    it.in_valid = iv;
    it.out_level = LEVEL_W'(ol);
    it.out_valid = ov;
    it.elapsed_ms = TIME_W'(dt);
    return it;
  endfunction

  function automatic out_item_t res(int b, int ic, int oc, int pk);
    out_item_t r;
    r.bin_out = BIN_W'(b);
    r.in_curve = LEVEL_W'(ic);
    r.out_curve = LEVEL_W'(oc);
    r.peak_max = LEVEL_W'(pk);
    return r;
  endfunction

  function automatic step_t row(in_item_t it, logic typed, out_item_t want);
    step_t s;
    s.item = it;
    s.typed = typed;
    s.want = want;
    return s;
  endfunction

  function automatic logic signed [LEVEL_W-1:0] pick_level(logic signed [LEVEL_W-1:0] anchor);
    int v;
    case ($urandom_range(0, 7))
      0: v = int'($urandom_range(0, 65535)) - 32768;
      1: v = $urandom_range(0, 1) ? 32767 : -32768;
      2, 3, 4: v = int'(anchor) + int'($urandom_range(0, 600)) - 300;
      default: v = int'(anchor) - int'($urandom_range(0, 4000));
    endcase
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return LEVEL_W'(v);
  endfunction

  task automatic send_item(in_item_t it, int gap, logic typed, out_item_t want);
    out_item_t predicted;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = meter_update(it);
    pending_results.push_back(typed ? want : predicted);
  endtask

  task automatic program_reg(logic [1:0] idx, logic [LEVEL_W-1:0] value);
    logic [PDATA_W-1:0] rd;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_W'({idx, 2'b00});
    pwdata <= PDATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_FLOOR: floor_q = value;
      REG_HOLD:  hold_q = value;
      REG_FALL:  fall_q = value;
      default: ;
    endcase
    if (idx == REG_SPARE) begin
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      return;
    end
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rd = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if (rd[LEVEL_W-1:0] !== value)
      flag($sformatf("register %0d reads %h, wrote %h", idx, rd[LEVEL_W-1:0], value));
  endtask

  task automatic drain();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic check_result(out_item_t got, out_item_t want);
    if (got.bin_out !== want.bin_out)
      flag($sformatf("bin_out %0d, want %0d", got.bin_out, want.bin_out));
    if (got.in_curve !== want.in_curve)
      flag($sformatf("bin %0d in_curve %0d, want %0d", want.bin_out, got.in_curve,
                     want.in_curve));
    if (got.out_curve !== want.out_curve)
      flag($sformatf("bin %0d out_curve %0d, want %0d", want.bin_out, got.out_curve,
                     want.out_curve));
    if (got.peak_max !== want.peak_max)
      flag($sformatf("bin %0d peak_max %0d, want %0d", want.bin_out, got.peak_max,
                     want.peak_max));
  endtask

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
      if (pending_results.size() == 0) flag("transaction on the result side with none expected");
      else check_result(out_data, pending_results.pop_front());
    end
  end

  initial begin : sink
    int stall;
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 23) == 0) sink_calm = !sink_calm;
      stall = sink_calm ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
    end
  end

  initial begin
    #3_000_000;
    $display("tb: errors");
    $finish;
  end

  initial begin : stimulus
    in_item_t it;
    int gap;
    bit src_calm;
    src_calm = 1'b0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    floor_q = FLOOR_RST;
    hold_q = HOLD_RST;
    fall_q = FALL_RST;
    for (int i = 0; i < BINS_DEF; i++) begin
      in_curve_mem[i] = FLOOR_RST;
      out_curve_mem[i] = FLOOR_RST;
      peak_mem[i] = FLOOR_RST;
      in_hold_mem[i] = '0;
      out_hold_mem[i] = '0;
    end

    steps.push_back(row(mk(FUNC_UPDATE, 0, -32768, 1, -32768, 1, 0), 1'b1,
                        res(0, FLOOR_RST, FLOOR_RST, FLOOR_RST)));
    steps.push_back(row(mk(FUNC_UPDATE, 0, 0, 0, 0, 0, 65535), 1'b1,
                        res(0, FLOOR_RST, FLOOR_RST, FLOOR_RST)));
    steps.push_back(row(mk(FUNC_UPDATE, 1, 32767, 1, 32767, 1, 65535), 1'b1,
                        res(1, 32767, 32767, 32767)));
    steps.push_back(row(mk(FUNC_UPDATE, 1, -32768, 1, -32768, 1, 0), 1'b1,
                        res(1, 32767, 32767, 32767)));
    steps.push_back(row(mk(FUNC_UPDATE, 1, -32768, 1, -32768, 1, 499), 1'b0, '0));
    steps.push_back(row(mk(FUNC_UPDATE, 1, -32768, 1, -32768, 1, 2), 1'b0, '0));
    steps.push_back(row(mk(FUNC_UPDATE, 1, -32768, 1, -32768, 1, 65535), 1'b0, '0));
    steps.push_back(row(mk(FUNC_CLEAR, 1, 32767, 1, 32767, 1, 65535), 1'b0, '0));
    steps.push_back(row(mk(FUNC_UPDATE, 511, 32767, 1, -32768, 0, 1), 1'b0, '0));
    steps.push_back(row(mk(FUNC_UPDATE, 511, 32767, 1, 0, 1, 65535), 1'b0, '0));
    steps.push_back(row(mk(FUNC_UPDATE, 511, -1, 1, -1, 0, 100), 1'b0, '0));
    steps.push_back(row(mk(FUNC_UPDATE, 510, -32768, 0, 32767, 1, 'hAAAA), 1'b0, '0));
    steps.push_back(row(mk(FUNC_UPDATE, 'h0AA, 'h5555, 1, -21846, 1, 'h5555), 1'b0, '0));
    steps.push_back(row(mk(FUNC_UPDATE, 'h155, -21846, 1, 'h5555, 1, 'hAAAA), 1'b0, '0));
    steps.push_back(row(mk(FUNC_UPDATE, 'h155, 'h5555, 1, -21846, 1, 'h5555), 1'b0, '0));
    steps.push_back(row(mk(FUNC_CLEAR, 511, 0, 0, 0, 0, 0), 1'b0, '0));
    steps.push_back(row(mk(FUNC_CLEAR, 0, -32768, 1, 32767, 1, 65535), 1'b0, '0));
    steps.push_back(row(mk(FUNC_UPDATE, 511, -32768, 1, -32768, 1, 300), 1'b0, '0));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (steps[i]) begin
      gap = $urandom_range(0, 15);
      send_item(steps[i].item, gap, steps[i].typed, steps[i].want);
    end

    for (int p = 0; p < N_PHASES; p++) begin
      if (p > 0) begin
        in_valid <= 1'b0;
        drain();
        case (p)
          1: begin
            program_reg(REG_FLOOR, 16'h7FFF);
            program_reg(REG_HOLD, 16'h0000);
            program_reg(REG_FALL, 16'hFFFF);
          end
          2: begin
            program_reg(REG_FLOOR, 16'h8000);
            program_reg(REG_HOLD, 16'hFFFF);
            program_reg(REG_FALL, 16'h0000);
          end
          default: begin
            program_reg(REG_FLOOR, LEVEL_W'($urandom));
            program_reg(REG_HOLD, TIME_W'($urandom_range(0, 300)));
            program_reg(REG_FALL, TIME_W'($urandom_range(1, 600)));
            if (p == 3) program_reg(REG_SPARE, LEVEL_W'($urandom));
          end
        endcase
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        it.func = ($urandom_range(0, 9) == 0) ? FUNC_CLEAR : FUNC_UPDATE;
        it.bin = ($urandom_range(0, 9) < 7) ? BIN_W'($urandom_range(0, 7))
                                            : BIN_W'($urandom_range(0, BINS_DEF - 1));
        it.in_level = pick_level(in_curve_mem[it.bin]);
        it.in_valid = ($urandom_range(0, 9) != 0);
        it.out_level = pick_level(out_curve_mem[it.bin]);
        it.out_valid = ($urandom_range(0, 9) != 0);
        it.elapsed_ms = ($urandom_range(0, 7) == 0) ? TIME_W'($urandom)
                                                     : TIME_W'($urandom_range(0, 120));
        if ($urandom_range(0, 23) == 0) src_calm = !src_calm;
        gap = src_calm ? 0 : $urandom_range(0, 15);
        send_item(it, gap, 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    drain();
    repeat (8) @(posedge clk);
    if (fault_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
